### hw/rtl/atv_pkg.sv
// ----------------------------------------------------------------------------
// atv_pkg
// Shared types, opcode codes and helpers for the ASCII timestamp validator.
// ----------------------------------------------------------------------------
package atv_pkg;

  localparam logic [1:0] OP_DATE_TIME = 2'd0;
  localparam logic [1:0] OP_DATE      = 2'd1;
  localparam logic [1:0] OP_TIME      = 2'd2;

  localparam int unsigned YearW  = 19;
  localparam int unsigned FieldW = 13;
  localparam int unsigned ModW   = 12;

  // 1000 and 100 are multiples of 25, so year mod 25 follows from the low two digits
  localparam logic signed [FieldW-1:0] Mod25Bias = 13'sd550;
  // floor(u * 5243 / 2^17) == floor(u / 25) for u < 43690
  localparam logic [12:0] Recip25 = 13'd5243;

  typedef struct packed {
    logic [1:0]               op;
    logic                     date_nz;
    logic                     time_nz;
    logic signed [YearW-1:0]  year;
    logic signed [FieldW-1:0] month;
    logic signed [FieldW-1:0] day;
    logic signed [FieldW-1:0] hour;
    logic signed [FieldW-1:0] minute;
    logic signed [FieldW-1:0] sec;
    logic [ModW-1:0]          mod_arg;
  } dec_t;

  typedef struct packed {
    logic [1:0]      op;
    logic            date_pre;
    logic            time_ok;
    logic [3:0]      month;
    logic [4:0]      day;
    logic [3:0]      year_lo;
    logic [6:0]      quot;
    logic [ModW-1:0] mod_arg;
  } rng_t;

  function automatic logic signed [8:0] digit(input logic [7:0] b);
    return $signed({1'b0, b}) - 9'sd48;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/atv_if.sv
// ----------------------------------------------------------------------------
// atv_in_if / atv_out_if
// Valid/ready channels carrying timestamp beats in and verdict beats out.
// ----------------------------------------------------------------------------
interface atv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] date_chars;
  logic [47:0] time_chars;

  modport source (output valid, output opcode, output date_chars, output time_chars,
                  input ready);
  modport sink   (input valid, input opcode, input date_chars, input time_chars,
                  output ready);
endinterface

interface atv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

### hw/rtl/ascii_timestamp_validator_core.sv
// Three register stages (decode, range, verdict) lie between an accepted input beat and its verdict.
// Throughput: one beat per cycle while the output is not stalled.
// Each stage fills a bubble even while a later one stalls; ready is low only when all are full.
// Reset clears the stage valid bits; the pipeline is empty and ready right after reset.
// ----------------------------------------------------------------------------
// ascii_timestamp_validator_core
// Checks an ASCII date/time stamp and returns one valid bit per beat.
// ----------------------------------------------------------------------------
module ascii_timestamp_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  atv_in_if.sink     req_i,
  atv_out_if.source  rsp_o
);

  logic          s1_valid;
  logic          s1_ready;
  atv_pkg::dec_t s1_data;
  logic          s2_valid;
  logic          s2_ready;
  atv_pkg::rng_t s2_data;

  atv_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (req_i.valid),
    .ready_o      (req_i.ready),
    .opcode_i     (req_i.opcode),
    .date_chars_i (req_i.date_chars),
    .time_chars_i (req_i.time_chars),
    .valid_o      (s1_valid),
    .ready_i      (s1_ready),
    .data_o       (s1_data)
  );

  atv_range u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  atv_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .data_i      (s2_data),
    .valid_o     (rsp_o.valid),
    .ready_i     (rsp_o.ready),
    .valid_res_o (rsp_o.valid_res)
  );

endmodule

### hw/rtl/atv_decode.sv
// ----------------------------------------------------------------------------
// atv_decode
// Stage 1: zero-byte detection and weighted digit sums of every field.
// ----------------------------------------------------------------------------
module atv_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [1:0]     opcode_i,
  input  logic [63:0]    date_chars_i,
  input  logic [47:0]    time_chars_i,
  output logic           valid_o,
  input  logic           ready_i,
  output atv_pkg::dec_t  data_o
);

  logic signed [8:0] dd [8];
  logic signed [8:0] td [6];
  logic [7:0]        date_zero;
  logic [5:0]        time_zero;
  logic signed [atv_pkg::FieldW-1:0] mod_sum;
  atv_pkg::dec_t     dec_d;
  atv_pkg::dec_t     dec_q;
  logic              valid_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      dd[k]        = atv_pkg::digit(date_chars_i[63-8*k -: 8]);
      date_zero[k] = (date_chars_i[63-8*k -: 8] == 8'd0);
    end
    for (int k = 0; k < 6; k++) begin
      td[k]        = atv_pkg::digit(time_chars_i[47-8*k -: 8]);
      time_zero[k] = (time_chars_i[47-8*k -: 8] == 8'd0);
    end
  end

  always_comb begin
    mod_sum       = 13'(dd[2]) * 13'sd10 + 13'(dd[3]) + atv_pkg::Mod25Bias;
    dec_d.op      = opcode_i;
    dec_d.date_nz = ~|date_zero;
    dec_d.time_nz = ~|time_zero;
    dec_d.year    = 19'(dd[0]) * 19'sd1000 + 19'(dd[1]) * 19'sd100
                  + 19'(dd[2]) * 19'sd10 + 19'(dd[3]);
    dec_d.month   = 13'(dd[4]) * 13'sd10 + 13'(dd[5]);
    dec_d.day     = 13'(dd[6]) * 13'sd10 + 13'(dd[7]);
    dec_d.hour    = 13'(td[0]) * 13'sd10 + 13'(td[1]);
    dec_d.minute  = 13'(td[2]) * 13'sd10 + 13'(td[3]);
    dec_d.sec     = 13'(td[4]) * 13'sd10 + 13'(td[5]);
    dec_d.mod_arg = mod_sum[atv_pkg::ModW-1:0];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

endmodule

### hw/rtl/atv_range.sv
// ----------------------------------------------------------------------------
// atv_range
// Stage 2: field range checks and reciprocal quotient for the mod-25 test.
// ----------------------------------------------------------------------------
module atv_range (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  atv_pkg::dec_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output atv_pkg::rng_t  data_o
);

  logic [24:0]   prod;
  logic          day_fits;
  atv_pkg::rng_t rng_d;
  atv_pkg::rng_t rng_q;
  logic          valid_q;

  always_comb begin
    prod     = 25'(data_i.mod_arg) * 25'(atv_pkg::Recip25);
    day_fits = (data_i.day >= 13'sd1) && (data_i.day <= 13'sd31);
    rng_d.op       = data_i.op;
    rng_d.date_pre = data_i.date_nz && (data_i.year >= 19'sd1)
                   && (data_i.month >= 13'sd1) && (data_i.month <= 13'sd12) && day_fits;
    rng_d.time_ok  = data_i.time_nz
                   && (data_i.hour >= 13'sd0) && (data_i.hour <= 13'sd23)
                   && (data_i.minute >= 13'sd0) && (data_i.minute <= 13'sd59)
                   && (data_i.sec >= 13'sd0) && (data_i.sec <= 13'sd59);
    rng_d.month    = data_i.month[3:0];
    rng_d.day      = data_i.day[4:0];
    rng_d.year_lo  = data_i.year[3:0];
    rng_d.quot     = prod[23:17];
    rng_d.mod_arg  = data_i.mod_arg;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rng_q <= rng_d;
    end
  end

endmodule

### hw/rtl/atv_verdict.sv
// ----------------------------------------------------------------------------
// atv_verdict
// Stage 3: leap year, day-of-month limit and opcode select into the output register.
// ----------------------------------------------------------------------------
module atv_verdict (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  atv_pkg::rng_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           valid_res_o
);

  logic [atv_pkg::ModW-1:0] rem;
  logic       div25;
  logic       leap;
  logic [4:0] lim;
  logic       date_ok;
  logic       res_d;
  logic       res_q;
  logic       valid_q;

  always_comb begin
    rem     = data_i.mod_arg - 12'(data_i.quot) * 12'd25;
    div25   = (rem == '0);
    leap    = (data_i.year_lo[1:0] == 2'd0) && (!div25 || (data_i.year_lo == 4'd0));
    lim     = atv_pkg::month_len(data_i.month)
            + 5'((data_i.month == 4'd2) && leap);
    date_ok = data_i.date_pre && (data_i.day <= lim);
    unique case (data_i.op)
      atv_pkg::OP_DATE_TIME: res_d = date_ok && data_i.time_ok;
      atv_pkg::OP_DATE:      res_d = date_ok;
      atv_pkg::OP_TIME:      res_d = data_i.time_ok;
      default:               res_d = 1'b0;
    endcase
  end

  assign ready_o     = !valid_q || ready_i;
  assign valid_o     = valid_q;
  assign valid_res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

endmodule

### hw/rtl/atv_checker.sv
// ----------------------------------------------------------------------------
// atv_checker
// Port-level checks of the validator pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module atv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_res_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_i))
    else $error("stalled output beat changed");

  // a verdict beat only leaves when taken
  a_out_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("output beat dropped without handshake");

  // empty output stage means the pipeline can take a beat
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output stage empty");

  // with no beat accepted and a willing sink, the decode, range and verdict stages empty in turn
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_ready_i) ##1 (!in_acc && out_ready_i) ##1 (!in_acc && out_ready_i)
    |=> !out_valid_i)
    else $error("pipeline did not drain");

endmodule

bind ascii_timestamp_validator_core atv_checker u_atv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_res_i   (rsp_o.valid_res)
);
